@@ sv/bcrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcrc_pkg
// Shared types and constants of the region CRC checker.
// ----------------------------------------------------------------------------
package bcrc_pkg;

   typedef logic [31:0] crc_word_type;
   typedef logic [2:0]  hdr_count_type;

   // Values of the crc_mode register.
   localparam logic ModeReflected = 1'b0;
   localparam logic ModeMsbFirst  = 1'b1;

   localparam crc_word_type PolyReflected = 32'h82F6_3B78;
   localparam crc_word_type PolyMsbFirst  = 32'h04C1_1DB7;
   localparam crc_word_type AllOnes       = 32'hFFFF_FFFF;
   localparam crc_word_type TopBit        = 32'h8000_0000;
   localparam crc_word_type ZeroWord      = 32'h0000_0000;

   localparam hdr_count_type HeaderBytes  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      crc_word_type crc_value;
      crc_word_type stored_value;
      logic         crc_match;
      logic         too_short;
   } rsp_item_type;

endpackage

@@ sv/bcrc_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcrc_req_if
// Valid/ready channel that carries one region byte per request.
// ----------------------------------------------------------------------------
interface bcrc_req_if;
   import bcrc_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/bcrc_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcrc_rsp_if
// Valid/ready channel that carries one check result per region.
// ----------------------------------------------------------------------------
interface bcrc_rsp_if;
   import bcrc_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/bcrc_fold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcrc_fold
// Folds one byte into the CRC accumulator, reflected or MSB-first.
// ----------------------------------------------------------------------------
module bcrc_fold (
   input  logic                  mode,
   input  bcrc_pkg::crc_word_type acc_in,
   input  logic [7:0]            data_byte,
   output bcrc_pkg::crc_word_type acc_out
);
   import bcrc_pkg::*;

   crc_word_type refl_acc;
   crc_word_type msb_acc;

   // Eight bit steps, unrolled; each is a shift and a conditional xor.
   always_comb begin
      refl_acc = acc_in ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         refl_acc = (refl_acc >> 1) ^ (refl_acc[0] ? PolyReflected : ZeroWord);
      end
   end

   always_comb begin
      msb_acc = acc_in ^ {data_byte, 24'd0};
      for (int k = 0; k < 8; k++) begin
         msb_acc = (msb_acc << 1) ^
                   (((msb_acc & TopBit) != ZeroWord) ? PolyMsbFirst : ZeroWord);
      end
   end

   assign acc_out = (mode == ModeMsbFirst) ? msb_acc : refl_acc;

endmodule

@@ sv/block_crc32_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_crc32_checker
// Gathers a four-byte stored checksum at the head of each region, runs the
// selected CRC over the remaining bytes and reports the comparison, or
// too_short for a region shorter than the header, on the region's last byte.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_chan  in         data_byte, first_byte, last_byte (one byte per request)
//  rsp_chan  out        crc_value, stored_value, crc_match, too_short
//  csr_*     in         crc_mode write (no read-back)
//
//  One request per cycle is sustained, save for the stall below; once the
//  last byte of its region is accepted, a result passes through the input
//  register, then the result register. The per-byte CRC update is one unrolled
//  eight-step fold between the two. Reset clears the mode, the region state
//  and both valid flags. A stalled result only holds back the pipeline when the
//  next byte is itself a last byte; other bytes keep flowing.
// ----------------------------------------------------------------------------
module block_crc32_checker (
   input  logic              clock,
   input  logic              reset,
   bcrc_req_if.sink          req_chan,
   bcrc_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import bcrc_pkg::*;

   logic          crc_mode_ff;
   logic          in_valid_ff;
   req_item_type  in_item_ff;
   crc_word_type  acc_ff,      acc_in;
   crc_word_type  hdr_word_ff, hdr_word_in;
   hdr_count_type hdr_cnt_ff,  hdr_cnt_in;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   logic          advance;
   logic          in_take;
   crc_word_type  acc_base;
   crc_word_type  word_base;
   hdr_count_type cnt_base;
   crc_word_type  acc_folded;
   crc_word_type  acc_next;
   crc_word_type  word_next;
   hdr_count_type cnt_next;
   crc_word_type  calc;

   // A byte leaves the input register unless it must load a busy result.
   assign advance = in_valid_ff &&
                    (!in_item_ff.last_byte || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_take = req_chan.valid && req_chan.ready;

   // A first mark discards whatever partial region was in progress.
   assign acc_base  = in_item_ff.first_byte ? ZeroWord : acc_ff;
   assign word_base = in_item_ff.first_byte ? ZeroWord : hdr_word_ff;
   assign cnt_base  = in_item_ff.first_byte ? 3'd0 : hdr_cnt_ff;

   bcrc_fold u_fold (
      .mode      (crc_mode_ff),
      .acc_in    (acc_base),
      .data_byte (in_item_ff.data_byte),
      .acc_out   (acc_folded)
   );

   always_comb begin
      if (cnt_base < HeaderBytes) begin
         word_next = word_base |
                     ({24'd0, in_item_ff.data_byte} << {cnt_base[1:0], 3'b000});
         cnt_next  = cnt_base + 3'd1;
         if (cnt_next == HeaderBytes) begin
            acc_next = (crc_mode_ff == ModeMsbFirst) ? ZeroWord : AllOnes;
         end else begin
            acc_next = acc_base;
         end
      end else begin
         word_next = word_base;
         cnt_next  = cnt_base;
         acc_next  = acc_folded;
      end
   end

   always_comb begin
      calc = ~acc_next;
      rsp_item_in.stored_value = word_next;
      if (cnt_next < HeaderBytes) begin
         rsp_item_in.crc_value = ZeroWord;
         rsp_item_in.crc_match = 1'b0;
         rsp_item_in.too_short = 1'b1;
      end else begin
         rsp_item_in.crc_value = calc;
         rsp_item_in.crc_match = (calc == word_next);
         rsp_item_in.too_short = 1'b0;
      end
   end

   always_comb begin
      acc_in      = acc_ff;
      hdr_word_in = hdr_word_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      if (advance) begin
         if (in_item_ff.last_byte) begin
            acc_in      = ZeroWord;
            hdr_word_in = ZeroWord;
            hdr_cnt_in  = 3'd0;
         end else begin
            acc_in      = acc_next;
            hdr_word_in = word_next;
            hdr_cnt_in  = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_mode_ff  <= ModeReflected;
         in_valid_ff  <= 1'b0;
         acc_ff       <= ZeroWord;
         hdr_word_ff  <= ZeroWord;
         hdr_cnt_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            crc_mode_ff <= csr_wr_data;
         end
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         acc_ff      <= acc_in;
         hdr_word_ff <= hdr_word_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         if (advance && in_item_ff.last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_item_ff <= req_chan.payload;
      end
      if (advance && in_item_ff.last_byte) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

`ifndef SYNTH
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      hdr_cnt_ff <= HeaderBytes)
      else $error("header count ran past the header length");

   a_last_loads_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.last_byte) |=> rsp_valid_ff)
      else $error("last byte advanced without loading a result");

   a_region_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.last_byte) |=> (hdr_cnt_ff == 3'd0 && acc_ff == ZeroWord))
      else $error("region state not cleared after last byte");

   a_short_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_item_ff.too_short && rsp_item_ff.crc_match))
      else $error("short region reported as a match");

   a_short_zero_crc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.too_short) |-> rsp_item_ff.crc_value == ZeroWord)
      else $error("short region carries a nonzero CRC");
`endif

endmodule
